// ===== src/crc32r_pkg.sv =====
// ----------------------------------------------------------------------------
// crc32r_pkg
// Shared widths and constants for the byte-wide CRC-32 shift-in register.
// ----------------------------------------------------------------------------
`default_nettype none

package crc32r_pkg;

	localparam int unsigned CRC_W  = 32;
	localparam int unsigned BYTE_W = 8;

	localparam logic [CRC_W-1:0] CRC_POLY = 32'h0040_0007;

	typedef logic [CRC_W-1:0]  crc_t;
	typedef logic [BYTE_W-1:0] byte_t;

endpackage : crc32r_pkg

`default_nettype wire

// ===== src/crc32r_if.sv =====
// ----------------------------------------------------------------------------
// crc32r channel interfaces
// Valid/ready channels for message bytes, CRC results and seed writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface crc32r_in_if;
	import crc32r_pkg::*;

	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  first_byte;
	logic  last_byte;

	modport source (output valid, output data_byte, output first_byte, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input first_byte, input last_byte,
		output ready);
endinterface : crc32r_in_if

interface crc32r_out_if;
	import crc32r_pkg::*;

	logic valid;
	logic ready;
	crc_t crc_value;
	logic message_done;

	modport source (output valid, output crc_value, output message_done, input ready);
	modport sink (input valid, input crc_value, input message_done, output ready);
endinterface : crc32r_out_if

interface crc32r_cfg_if;
	import crc32r_pkg::*;

	logic valid;
	logic ready;
	crc_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface : crc32r_cfg_if

`default_nettype wire

// ===== src/crc32r_step.sv =====
// ----------------------------------------------------------------------------
// crc32r_step
// Feeds one byte, most significant bit first, into the CRC register.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32r_step (
	input  wire crc32r_pkg::crc_t  crc_in,
	input  wire crc32r_pkg::byte_t data_in,
	output crc32r_pkg::crc_t       crc_out
);
	import crc32r_pkg::*;

	// Eight bit steps unrolled into one XOR network.
	always_comb begin
		crc_t acc;
		logic top;
		acc = crc_in;
		for (int k = BYTE_W - 1; k >= 0; k--) begin
			top = acc[CRC_W-1];
			acc = {acc[CRC_W-2:0], data_in[k]};
			if (top) begin
				acc = acc ^ CRC_POLY;
			end
		end
		crc_out = acc;
	end

endmodule : crc32r_step

`default_nettype wire

// ===== src/crc32_reg_poly_400007_bytewise.sv =====
// ----------------------------------------------------------------------------
// crc32_reg_poly_400007_bytewise
// Byte-wide CRC-32 shift-in register, polynomial 0x400007.
// ----------------------------------------------------------------------------
// Usage:
// Bytes arrive on in_ch; each accepted beat carries one message byte, a
// first_byte flag that reloads the CRC register from the seed before the
// byte, and a last_byte mark. Every input beat produces exactly one beat on
// out_ch with the CRC register after that byte and message_done echoing
// last_byte. The seed is written through cfg, which is always ready; write
// it only while no byte is in flight.
// An accepted input beat reaches out_ch through one input register, then
// the result register. Throughput is one byte per cycle while out_ch does
// not stall, set by the eight-bit XOR network that updates the CRC
// register.
// When out_ch stalls, the result register holds and the input register can
// still take one more byte; in_ch.ready drops only when both are full.
// Reset clears the seed and the CRC register to zero and empties both
// stages.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32_reg_poly_400007_bytewise (
	input  wire          clk,
	input  wire          arst_n,
	crc32r_in_if.sink    in_ch,
	crc32r_out_if.source out_ch,
	crc32r_cfg_if.sink   cfg
);
	import crc32r_pkg::*;

	crc_t  seed_q;
	crc_t  crc_q;
	logic  valid_s1;
	byte_t byte_s1;
	logic  first_s1;
	logic  last_s1;
	logic  out_valid_q;
	logic  done_q;
	logic  advance;
	crc_t  crc_start;
	crc_t  crc_next;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg.valid) begin
			seed_q <= cfg.data;
		end
	end

	// The input stage moves on whenever the result register is free or drains.
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1  <= in_ch.data_byte;
			first_s1 <= in_ch.first_byte;
			last_s1  <= in_ch.last_byte;
		end
	end

	assign crc_start = first_s1 ? seed_q : crc_q;

	crc32r_step u_step (
		.crc_in  (crc_start),
		.data_in (byte_s1),
		.crc_out (crc_next)
	);

	// The running CRC register doubles as the result payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= '0;
			out_valid_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (advance) begin
				crc_q  <= crc_next;
				done_q <= last_s1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.crc_value    = crc_q;
	assign out_ch.message_done = done_q;

	a_advance_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("result register empty after a byte moved on");

	a_crc_holds_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(crc_q))
		else $error("CRC register changed without a byte");

	a_stage_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1) && $stable(first_s1)))
		else $error("stalled input stage lost its byte");

endmodule : crc32_reg_poly_400007_bytewise

`default_nettype wire
